/* design/hvn_pkg.sv */
// Shared types and constants of the heightmap vertex normal block.
// No dependencies; every other design file takes names from here.
`default_nettype none
package hvn_pkg;

  localparam int FACE_W = 17;
  localparam int SUM_W = 19;
  localparam int SY_W = 18;
  localparam int COL_W = 10;
  localparam int ROW_W = 16;
  localparam int QPTR_W = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W = 3;

  localparam logic [1:0] CFG_GRID_STEP = 2'd0;
  localparam logic [1:0] CFG_WIDTH = 2'd1;
  localparam logic [1:0] CFG_ROWS = 2'd2;

  localparam logic [15:0] GRID_STEP_RESET = 16'd256;
  localparam logic [10:0] WIDTH_RESET = 11'd100;
  localparam logic [15:0] ROWS_RESET = 16'd100;

  typedef struct packed {
    logic signed [FACE_W-1:0] x;
    logic signed [FACE_W-1:0] z;
  } face_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sx;
    logic [SY_W-1:0] sy;
    logic signed [SUM_W-1:0] sz;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic last;
  } sum_entry_t;

  typedef struct packed {
    logic empty;
    logic [QCNT_W-1:0] free;
  } queue_status_t;

endpackage
`default_nettype wire

/* design/hvn_queue.sv */
// Short queue of face sums between the front and the normalizing back end.
// Depends on hvn_pkg.
`default_nettype none
module hvn_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire hvn_pkg::sum_entry_t push_entry,
  input  wire logic pop,
  output hvn_pkg::sum_entry_t pop_entry,
  output hvn_pkg::queue_status_t status
);

  hvn_pkg::sum_entry_t slots [hvn_pkg::QUEUE_DEPTH];
  logic [hvn_pkg::QPTR_W-1:0] head;
  logic [hvn_pkg::QPTR_W-1:0] tail;
  logic [hvn_pkg::QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      if (push) tail <= tail + 1'b1;
      if (pop) head <= head + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  assign pop_entry = slots[head];
  assign status.empty = (count == '0);
  assign status.free = hvn_pkg::QCNT_W'(hvn_pkg::QUEUE_DEPTH) - count;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < hvn_pkg::QCNT_W'(hvn_pkg::QUEUE_DEPTH))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !push && !pop |=> count == $past(count))
    else $error("queue count moved without push or pop");

endmodule
`default_nettype wire

/* design/hvn_front.sv */
// Front end: configuration, raster counters, line stores and face sums.
// Depends on hvn_pkg; feeds hvn_queue.
`default_nettype none
module hvn_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_write_enable,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [15:0] height,
  input  wire hvn_pkg::queue_status_t q_status,
  output logic push,
  output hvn_pkg::sum_entry_t push_entry
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_RD = 2'd1;
  localparam logic [1:0] F_CALC = 2'd2;
  localparam logic [1:0] F_SECOND = 2'd3;

  logic signed [15:0] height_line [MAX_WIDTH];
  hvn_pkg::face_t face_line [MAX_WIDTH];

  logic [15:0] grid_step;
  logic [10:0] width_cfg;
  logic [15:0] rows_cfg;
  logic [AW-1:0] col_count;
  logic [15:0] row_count;
  logic [1:0] state;
  logic signed [15:0] h_q;
  logic signed [15:0] hu_q;
  logic signed [15:0] hr_q;
  logic [AW-1:0] c_q;
  logic [15:0] r_q;
  hvn_pkg::face_t up_q;
  hvn_pkg::face_t face_left;
  hvn_pkg::face_t face_upper_left;
  hvn_pkg::sum_entry_t second_q;

  logic [WW-1:0] w_eff;
  logic [15:0] rows_eff;
  logic [AW-1:0] c_cur;
  logic [15:0] r_cur;
  logic row_end;
  logic accept;
  logic has_right, has_left, has_up, last_row, proceed;
  logic [15:0] g_eff;
  hvn_pkg::face_t cur;
  logic signed [16:0] ul_x, ul_z, ur_x, ur_z, l_x, l_z, r_x, r_z;
  logic [2:0] cnt1, cnt2;
  logic [17:0] sy1, sy2;
  hvn_pkg::sum_entry_t first_e, second_e;

  always_comb begin
    if (width_cfg < 11'd2) w_eff = WW'(2);
    else if (32'(width_cfg) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_cfg);
  end

  assign rows_eff = (rows_cfg < 16'd2) ? 16'd2 : rows_cfg;
  assign c_cur = (WW'(col_count) >= w_eff) ? '0 : col_count;
  assign r_cur = (row_count >= rows_eff) ? '0 : row_count;
  assign row_end = (WW'(c_cur) + WW'(1)) >= w_eff;
  assign accept = in_valid && (state == F_IDLE);
  assign in_stall = (state != F_IDLE);

  assign has_right = (WW'(c_q) + WW'(1)) < w_eff;
  assign has_left = (c_q != '0);
  assign has_up = (r_q >= 16'd2);
  assign last_row = ({1'b0, r_q} + 17'd1) == {1'b0, rows_eff};
  assign g_eff = (grid_step == 16'd0) ? 16'd1 : grid_step;
  assign proceed = (r_q == 16'd0) || (q_status.free >= hvn_pkg::QCNT_W'(2));

  always_comb begin
    cur.x = has_right ? (17'(hu_q) - 17'(hr_q)) : '0;
    cur.z = has_right ? (17'(hu_q) - 17'(h_q)) : '0;
    ul_x = (has_up && has_left) ? face_upper_left.x : '0;
    ul_z = (has_up && has_left) ? face_upper_left.z : '0;
    ur_x = (has_up && has_right) ? up_q.x : '0;
    ur_z = (has_up && has_right) ? up_q.z : '0;
    l_x = has_left ? face_left.x : '0;
    l_z = has_left ? face_left.z : '0;
    r_x = cur.x;
    r_z = cur.z;
    cnt2 = {2'd0, has_left} + {2'd0, has_right};
    cnt1 = cnt2 + {2'd0, has_up && has_left} + {2'd0, has_up && has_right};
    sy1 = {15'd0, cnt1} * {2'd0, g_eff};
    sy2 = {15'd0, cnt2} * {2'd0, g_eff};
    first_e.sx = 19'(ul_x) + 19'(ur_x) + 19'(l_x) + 19'(r_x);
    first_e.sz = 19'(ul_z) + 19'(ur_z) + 19'(l_z) + 19'(r_z);
    first_e.sy = sy1;
    first_e.column = hvn_pkg::COL_W'(c_q);
    first_e.row = r_q - 16'd1;
    first_e.last = !last_row;
    second_e.sx = 19'(l_x) + 19'(r_x);
    second_e.sz = 19'(l_z) + 19'(r_z);
    second_e.sy = sy2;
    second_e.column = hvn_pkg::COL_W'(c_q);
    second_e.row = r_q;
    second_e.last = 1'b1;
  end

  assign push = ((state == F_CALC) && (r_q != 16'd0) && proceed) || (state == F_SECOND);
  assign push_entry = (state == F_SECOND) ? second_q : first_e;

  always_ff @(posedge clk) begin
    if (state == F_RD) begin
      hu_q <= height_line[c_q];
      hr_q <= height_line[c_q + AW'(1)];
      up_q <= face_line[c_q];
    end
    if (state == F_CALC && proceed) begin
      height_line[c_q] <= h_q;
      if (r_q != 16'd0) face_line[c_q] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_q <= height;
      c_q <= c_cur;
      r_q <= r_cur;
    end
    if (state == F_CALC) second_q <= second_e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_step <= hvn_pkg::GRID_STEP_RESET;
      width_cfg <= hvn_pkg::WIDTH_RESET;
      rows_cfg <= hvn_pkg::ROWS_RESET;
      col_count <= '0;
      row_count <= '0;
      state <= F_IDLE;
      face_left <= '0;
      face_upper_left <= '0;
    end else begin
      if (cfg_write_enable) begin
        unique case (cfg_index)
          hvn_pkg::CFG_GRID_STEP: grid_step <= cfg_data;
          hvn_pkg::CFG_WIDTH: begin
            width_cfg <= cfg_data[10:0];
            col_count <= '0;
            row_count <= '0;
          end
          hvn_pkg::CFG_ROWS: begin
            rows_cfg <= cfg_data;
            col_count <= '0;
            row_count <= '0;
          end
          default: ;
        endcase
      end else if (accept) begin
        if (row_end) begin
          col_count <= '0;
          row_count <= (({1'b0, r_cur} + 17'd1) >= {1'b0, rows_eff}) ? 16'd0 : r_cur + 16'd1;
        end else begin
          col_count <= c_cur + AW'(1);
        end
      end
      unique case (state)
        F_IDLE: if (accept) state <= F_RD;
        F_RD: state <= F_CALC;
        F_CALC: begin
          if (proceed) begin
            if (r_q != 16'd0) begin
              face_upper_left <= up_q;
              face_left <= cur;
            end
            state <= (r_q != 16'd0 && last_row) ? F_SECOND : F_IDLE;
          end
        end
        F_SECOND: state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/hvn_back.sv */
// Back end: bit-serial square root and three parallel restoring dividers
// that turn one face sum into a unit normal. Depends on hvn_pkg.
`default_nettype none
module hvn_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire hvn_pkg::queue_status_t q_status,
  input  wire hvn_pkg::sum_entry_t pop_entry,
  output logic pop,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic [9:0] column,
  output logic [15:0] row,
  output logic last_of_run
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_SQ = 3'd1;
  localparam logic [2:0] B_LEN = 3'd2;
  localparam logic [2:0] B_ROOT = 3'd3;
  localparam logic [2:0] B_DSET = 3'd4;
  localparam logic [2:0] B_DIV = 3'd5;
  localparam logic [2:0] B_OUT = 3'd6;

  localparam logic [14:0] Q_ONE = 15'd16384;

  logic [2:0] state;
  logic [4:0] step;
  hvn_pkg::sum_entry_t ent;
  logic [17:0] mx, my, mz;
  logic [35:0] sqx, sqy, sqz;
  logic [57:0] op, res, one;
  logic [42:0] rem_x, rem_y, rem_z, dv;
  logic [14:0] qx, qy, qz;
  logic zero_len;

  logic [17:0] ax, az;
  logic [37:0] len;
  logic [57:0] trial;

  assign ax = ent.sx[18] ? 18'(-ent.sx) : 18'(ent.sx);
  assign az = ent.sz[18] ? 18'(-ent.sz) : 18'(ent.sz);
  assign len = 38'(sqx) + 38'(sqy) + 38'(sqz);
  assign trial = res + one;
  assign pop = (state == B_IDLE) && !q_status.empty;

  function automatic logic signed [15:0] apply_sign(input logic [14:0] q, input logic neg);
    logic [15:0] v;
    v = {1'b0, (q > Q_ONE) ? Q_ONE : q};
    return neg ? -v : v;
  endfunction

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: if (pop) ent <= pop_entry;
      B_SQ: begin
        mx <= ax;
        my <= ent.sy;
        mz <= az;
        sqx <= ax * ax;
        sqy <= ent.sy * ent.sy;
        sqz <= az * az;
      end
      B_LEN: begin
        op <= {len, 20'd0};
        res <= '0;
        one <= 58'd1 << 56;
      end
      B_ROOT: begin
        if (op >= trial) begin
          op <= op - trial;
          res <= (res >> 1) + one;
        end else begin
          res <= res >> 1;
        end
        one <= one >> 2;
      end
      B_DSET: begin
        rem_x <= {1'b0, mx, 24'd0} + 43'(res >> 1);
        rem_y <= {1'b0, my, 24'd0} + 43'(res >> 1);
        rem_z <= {1'b0, mz, 24'd0} + 43'(res >> 1);
        dv <= {res[28:0], 14'd0};
        zero_len <= (res == '0);
        qx <= '0;
        qy <= '0;
        qz <= '0;
      end
      B_DIV: begin
        if (rem_x >= dv) begin
          rem_x <= rem_x - dv;
          qx <= {qx[13:0], 1'b1};
        end else qx <= {qx[13:0], 1'b0};
        if (rem_y >= dv) begin
          rem_y <= rem_y - dv;
          qy <= {qy[13:0], 1'b1};
        end else qy <= {qy[13:0], 1'b0};
        if (rem_z >= dv) begin
          rem_z <= rem_z - dv;
          qz <= {qz[13:0], 1'b1};
        end else qz <= {qz[13:0], 1'b0};
        dv <= dv >> 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      step <= '0;
    end else begin
      unique case (state)
        B_IDLE: if (pop) state <= B_SQ;
        B_SQ: state <= B_LEN;
        B_LEN: begin
          step <= '0;
          state <= B_ROOT;
        end
        B_ROOT: begin
          step <= step + 5'd1;
          if (step == 5'd28) state <= B_DSET;
        end
        B_DSET: begin
          step <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          step <= step + 5'd1;
          if (step == 5'd14) state <= B_OUT;
        end
        B_OUT: if (!out_stall) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  assign out_valid = (state == B_OUT);
  assign normal_x = zero_len ? 16'sd0 : apply_sign(qx, ent.sx[18]);
  assign normal_y = zero_len ? 16'sd16384 : apply_sign(qy, 1'b0);
  assign normal_z = zero_len ? 16'sd0 : apply_sign(qz, ent.sz[18]);
  assign column = ent.column;
  assign row = ent.row;
  assign last_of_run = ent.last;

endmodule
`default_nettype wire

/* design/heightmap_vertex_normals.sv */
// Top level of the heightmap vertex normal block: front, queue and back end.
// Depends on hvn_pkg, hvn_front, hvn_queue and hvn_back.
//
//   channel  signals                               direction
//   config   cfg_write_enable cfg_index cfg_data   in, write only
//   height   in_valid in_stall height              in, one word per vertex
//   normal   out_valid out_stall normal_* column   out, zero to two words
//            row last_of_run                       per height word
//
// Front takes a height word only when idle; it stalls through its read, sum and, on
// the last row, second-push states, and past row 0 until two queue slots are free. Each
// normal word takes 29 square root and 15 divide steps, one bit per cycle, plus setup and hand-off.
// Reset (rst, synchronous) restores the register defaults and row 0, column 0.
// A stalled output holds the back end; the four-entry queue keeps the front
// taking words until fewer than two slots are free.
`default_nettype none
module heightmap_vertex_normals #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_write_enable,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [15:0] height,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic [9:0] column,
  output logic [15:0] row,
  output logic last_of_run
);

  logic push, pop;
  hvn_pkg::sum_entry_t push_entry, pop_entry;
  hvn_pkg::queue_status_t q_status;

  hvn_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk(clk), .rst(rst),
    .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .height(height),
    .q_status(q_status), .push(push), .push_entry(push_entry)
  );

  hvn_queue u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_entry(push_entry),
    .pop(pop), .pop_entry(pop_entry), .status(q_status)
  );

  hvn_back u_back (
    .clk(clk), .rst(rst),
    .q_status(q_status), .pop_entry(pop_entry), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .column(column), .row(row), .last_of_run(last_of_run)
  );

endmodule
`default_nettype wire
